// ----- rtl/tsbrm_pkg.sv -----
// Package for the bit rate meter: widths, reset values, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package tsbrm_pkg;

   localparam int SLICES   = 10;
   localparam int RING_LEN = SLICES + 1;
   localparam int IDX_W    = $clog2(RING_LEN);
   localparam int FILL_W   = $clog2(RING_LEN + 1);
   localparam int SUM_W    = FILL_W + 1;

   localparam int TIME_W     = 48;
   localparam int COUNT_W    = 48;
   localparam int RATE_W     = 40;
   localparam int LWIN_W     = 32;
   localparam int SLICE_W    = 32;
   localparam int PB_W       = 16;
   localparam int SCALE_W    = 20;
   localparam int NUM_W      = 84;
   localparam int WIDE_W     = TIME_W + RATE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W     = 6;

   localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [RATE_W-1:0]  RATE_MAX = '1;

   localparam logic [LWIN_W-1:0]  LWIN_RST  = 32'd1000000;
   localparam logic [SLICE_W-1:0] SLICE_RST = 32'd100000;
   localparam logic [PB_W-1:0]    PB_RST    = 16'd1504;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_BITS = 2'd2;

   localparam logic [STEP_W-1:0] MUL1_LAST = STEP_W'(PB_W - 1);
   localparam logic [STEP_W-1:0] MUL2_LAST = STEP_W'(SCALE_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RATE_W - 1);

   localparam logic [FILL_W-1:0] RING_LEN_F = FILL_W'(RING_LEN);
   localparam logic [IDX_W-1:0]  RING_LAST  = IDX_W'(RING_LEN - 1);
   localparam logic [SUM_W-1:0]  RING_LEN_S = SUM_W'(RING_LEN);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LCHK,
      ST_MINIT,
      ST_MUL1,
      ST_MINIT2,
      ST_MUL2,
      ST_DINIT,
      ST_DIV,
      ST_STORE,
      ST_RD_NEW,
      ST_RCHK,
      ST_RD_HEAD,
      ST_SLOAD,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load_in;
      logic start_win;
      logic load_long;
      logic rd_en;
      logic rd_head;
      logic take;
      logic load_slide;
      logic mul_init1;
      logic mul_init2;
      logic mul_step;
      logic div_init;
      logic div_step;
      logic store_long;
      logic store_slide;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic started;
      logic long_due;
      logic take_due;
      logic ring_full;
      logic skip_div;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage
`default_nettype wire

// ----- rtl/tsbrm_ifs.sv -----
// Valid/ready channel interfaces of the bit rate meter: tick in, rates out, register writes.
// Depends on tsbrm_pkg.
`default_nettype none
interface tsbrm_req_if import tsbrm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  now_us;
   logic [COUNT_W-1:0] packet_count;
   modport source (output valid, now_us, packet_count, input ready);
   modport sink (input valid, now_us, packet_count, output ready);
endinterface

interface tsbrm_rsp_if import tsbrm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] long_rate_bps;
   logic              long_rate_valid;
   logic [RATE_W-1:0] sliding_rate_bps;
   logic              sliding_rate_valid;
   modport source (output valid, long_rate_bps, long_rate_valid, sliding_rate_bps,
                   sliding_rate_valid, input ready);
   modport sink (input valid, long_rate_bps, long_rate_valid, sliding_rate_bps,
                 sliding_rate_valid, output ready);
endinterface

interface tsbrm_csr_if import tsbrm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tsbrm_dp.sv -----
// Datapath of the bit rate meter: config registers, window and ring state, sample ring
// memory, shift-add multiplier, restoring divider and result register. Uses tsbrm_pkg.
`default_nettype none
module tsbrm_dp import tsbrm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           sts,
   input  wire csr_wr_type         csr_wr,
   input  wire logic [TIME_W-1:0]  now_us,
   input  wire logic [COUNT_W-1:0] packet_count,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [RATE_W-1:0]       long_rate_bps,
   output logic                    long_rate_valid,
   output logic [RATE_W-1:0]       sliding_rate_bps,
   output logic                    sliding_rate_valid
);

   // configuration
   logic [LWIN_W-1:0]  lwin_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [PB_W-1:0]    pb_ff;

   // window and ring control state
   logic               started_ff;
   logic [TIME_W-1:0]  wst_ff;
   logic [COUNT_W-1:0] wsc_ff;
   logic [RATE_W-1:0]  long_rate_ff;
   logic               long_valid_ff;
   logic [RATE_W-1:0]  slide_rate_ff;
   logic               slide_valid_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               rsp_valid_ff;

   // sample ring
   logic [TIME_W-1:0]  time_mem [RING_LEN];
   logic [COUNT_W-1:0] count_mem [RING_LEN];
   logic [TIME_W-1:0]  rd_time_ff;
   logic [COUNT_W-1:0] rd_count_ff;

   // working registers
   logic [TIME_W-1:0]  now_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] pk_ff;
   logic [TIME_W-1:0]  el_ff;
   logic [NUM_W-1:0]   acc_ff;
   logic [NUM_W-1:0]   mcand_ff;
   logic [SCALE_W-1:0] mplier_ff;
   logic [TIME_W-1:0]  rem_ff;
   logic [RATE_W-1:0]  nlo_ff;
   logic               sat_ff;
   logic [RATE_W-1:0]  long_out_ff;
   logic               long_vout_ff;
   logic [RATE_W-1:0]  slide_out_ff;
   logic               slide_vout_ff;

   logic [TIME_W-1:0]  el_long;
   logic [TIME_W-1:0]  el_slice;
   logic [SUM_W-1:0]   newest_sum;
   logic [SUM_W-1:0]   newest_wrap;
   logic [SUM_W-1:0]   app_sum;
   logic [SUM_W-1:0]   app_wrap;
   logic [IDX_W-1:0]   head_inc;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   slot;
   logic               ring_full;
   logic [WIDE_W-1:0]  num_ext;
   logic [WIDE_W-1:0]  el_shift;
   logic               el_zero;
   logic [TIME_W:0]    div_t;
   logic [TIME_W:0]    div_d;
   logic               div_ge;
   logic [TIME_W-1:0]  rem_in;
   logic [RATE_W-1:0]  rate_res;

   assign el_long  = now_ff - wst_ff;
   assign el_slice = now_ff - rd_time_ff;
   assign ring_full = (fill_ff == RING_LEN_F);

   assign newest_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff) - SUM_W'(1);
   assign newest_wrap = (newest_sum >= RING_LEN_S) ? newest_sum - RING_LEN_S : newest_sum;
   assign app_sum     = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign app_wrap    = (app_sum >= RING_LEN_S) ? app_sum - RING_LEN_S : app_sum;
   assign head_inc    = (head_ff == RING_LAST) ? '0 : head_ff + IDX_W'(1);
   assign rd_addr     = cmd.rd_head ? head_ff : newest_wrap[IDX_W-1:0];
   assign slot        = ring_full ? head_ff : app_wrap[IDX_W-1:0];

   assign num_ext  = WIDE_W'(acc_ff);
   assign el_shift = {el_ff, {RATE_W{1'b0}}};
   assign el_zero  = (el_ff == '0);

   assign div_t  = {rem_ff, nlo_ff[RATE_W-1]};
   assign div_d  = div_t - {1'b0, el_ff};
   assign div_ge = (div_t >= {1'b0, el_ff});
   assign rem_in = div_ge ? div_d[TIME_W-1:0] : div_t[TIME_W-1:0];

   assign rate_res = sat_ff ? RATE_MAX : (el_zero ? '0 : nlo_ff);

   always_comb begin
      sts.started   = started_ff;
      sts.long_due  = (el_long >= TIME_W'(lwin_ff));
      sts.take_due  = (fill_ff == '0) || (el_slice >= TIME_W'(slice_ff));
      sts.ring_full = ring_full;
      sts.skip_div  = sat_ff || el_zero;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lwin_ff        <= LWIN_RST;
         slice_ff       <= SLICE_RST;
         pb_ff          <= PB_RST;
         started_ff     <= 1'b0;
         wst_ff         <= '0;
         wsc_ff         <= '0;
         long_rate_ff   <= '0;
         long_valid_ff  <= 1'b0;
         slide_rate_ff  <= '0;
         slide_valid_ff <= 1'b0;
         head_ff        <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr.we) begin
            case (csr_wr.index)
               CSR_LONG_WINDOW: lwin_ff  <= csr_wr.data[LWIN_W-1:0];
               CSR_SLICE:       slice_ff <= csr_wr.data[SLICE_W-1:0];
               CSR_PACKET_BITS: pb_ff    <= csr_wr.data[PB_W-1:0];
               default: ;
            endcase
         end
         if (cmd.start_win) begin
            started_ff <= 1'b1;
            wst_ff     <= now_ff;
            wsc_ff     <= cnt_ff;
         end
         if (cmd.load_long) begin
            wst_ff <= now_ff;
            wsc_ff <= cnt_ff;
         end
         if (cmd.take) begin
            if (ring_full) begin
               head_ff <= head_inc;
            end else begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end
         if (cmd.store_long) begin
            long_rate_ff  <= rate_res;
            long_valid_ff <= 1'b1;
         end
         if (cmd.store_slide) begin
            slide_rate_ff  <= rate_res;
            slide_valid_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         time_mem[slot]  <= now_ff;
         count_mem[slot] <= cnt_ff;
      end
      if (cmd.rd_en) begin
         rd_time_ff  <= time_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         now_ff <= now_us;
         cnt_ff <= packet_count;
      end
      if (cmd.load_long) begin
         pk_ff <= cnt_ff - wsc_ff;
         el_ff <= el_long;
      end
      if (cmd.load_slide) begin
         pk_ff <= cnt_ff - rd_count_ff;
         el_ff <= el_slice;
      end
      if (cmd.mul_init1) begin
         acc_ff    <= '0;
         mcand_ff  <= NUM_W'(pk_ff);
         mplier_ff <= SCALE_W'(pb_ff);
      end
      if (cmd.mul_init2) begin
         acc_ff    <= '0;
         mcand_ff  <= acc_ff;
         mplier_ff <= US_PER_S;
      end
      if (cmd.mul_step) begin
         acc_ff    <= acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_ff  <= {mcand_ff[NUM_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[SCALE_W-1:1]};
      end
      if (cmd.div_init) begin
         rem_ff <= TIME_W'(acc_ff[NUM_W-1:RATE_W]);
         nlo_ff <= acc_ff[RATE_W-1:0];
         sat_ff <= el_zero ? (pk_ff != '0) : (num_ext >= el_shift);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         nlo_ff <= {nlo_ff[RATE_W-2:0], div_ge};
      end
      if (cmd.out_load) begin
         long_out_ff   <= long_rate_ff;
         long_vout_ff  <= long_valid_ff;
         slide_out_ff  <= slide_rate_ff;
         slide_vout_ff <= slide_valid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign long_rate_bps      = long_out_ff;
   assign long_rate_valid    = long_vout_ff;
   assign sliding_rate_bps   = slide_out_ff;
   assign sliding_rate_valid = slide_vout_ff;

endmodule
`default_nettype wire

// ----- rtl/tsbrm_ctrl.sv -----
// Controller of the bit rate meter: sequences window check, ring update, the
// multiply and divide steps and the result beat. Uses tsbrm_pkg.
`default_nettype none
module tsbrm_ctrl import tsbrm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type sts,
   output dp_cmd_type         cmd
);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              slide_ff, slide_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         slide_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         slide_ff <= slide_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      slide_in  = slide_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_LCHK;
            end
         end
         ST_LCHK: begin
            if (!sts.started) begin
               cmd.start_win = 1'b1;
               state_in      = ST_RD_NEW;
            end else if (sts.long_due) begin
               cmd.load_long = 1'b1;
               slide_in      = 1'b0;
               state_in      = ST_MINIT;
            end else begin
               state_in = ST_RD_NEW;
            end
         end
         ST_MINIT: begin
            cmd.mul_init1 = 1'b1;
            step_in       = '0;
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == MUL1_LAST) begin
               state_in = ST_MINIT2;
            end
         end
         ST_MINIT2: begin
            cmd.mul_init2 = 1'b1;
            step_in       = '0;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == MUL2_LAST) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (sts.skip_div) begin
               state_in = ST_STORE;
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + STEP_W'(1);
               if (step_ff == DIV_LAST) begin
                  state_in = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            if (slide_ff) begin
               cmd.store_slide = 1'b1;
               state_in        = ST_OUT;
            end else begin
               cmd.store_long = 1'b1;
               state_in       = ST_RD_NEW;
            end
         end
         ST_RD_NEW: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_RCHK;
         end
         ST_RCHK: begin
            if (sts.take_due) begin
               cmd.take = 1'b1;
               state_in = ST_RD_HEAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RD_HEAD: begin
            if (sts.ring_full) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_head = 1'b1;
               state_in    = ST_SLOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SLOAD: begin
            cmd.load_slide = 1'b1;
            slide_in       = 1'b1;
            state_in       = ST_MINIT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ts_bitrate_meter.sv -----
// Bit rate meter top level: fixed and sliding window rates from timestamped packet counts.
// One tick at a time: no multiply or divide runs when no window closes and no
// sample is taken, and both rates are recomputed in turn when both fall due. Each rate costs
// 16 + 20 shift-add multiply steps and up to 40 restoring divide steps in one shared unit.
// A new tick is taken once the previous result sits in the output register.
// Synchronous active-high reset restores register defaults, clears both stored rates and empties the ring.
// Depends on tsbrm_pkg, tsbrm_ifs, tsbrm_ctrl and tsbrm_dp.
`default_nettype none
module ts_bitrate_meter import tsbrm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tsbrm_req_if.sink   req_bus,
   tsbrm_rsp_if.source rsp_bus,
   tsbrm_csr_if.sink   csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type sts;
   csr_wr_type    csr_wr;
   logic          req_ready;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   always_comb begin
      csr_wr.we    = csr_bus.valid;
      csr_wr.index = csr_bus.index;
      csr_wr.data  = csr_bus.data;
   end

   tsbrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsbrm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_wr             (csr_wr),
      .now_us             (req_bus.now_us),
      .packet_count       (req_bus.packet_count),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .long_rate_bps      (rsp_bus.long_rate_bps),
      .long_rate_valid    (rsp_bus.long_rate_valid),
      .sliding_rate_bps   (rsp_bus.sliding_rate_bps),
      .sliding_rate_valid (rsp_bus.sliding_rate_valid)
   );

endmodule
`default_nettype wire

// ----- test/tb_ts_bitrate_meter.sv -----
// Testbench for ts_bitrate_meter: directed and random ticks under varied register settings,
// sender gaps and receiver stalls, with an in-bench rate predictor checking every result beat.
// Depends on tsbrm_pkg, tsbrm_ifs and the ts_bitrate_meter RTL.
`default_nettype none
module tb_ts_bitrate_meter;
   import tsbrm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 1500000;
   localparam int unsigned DRAIN_CYCLES = 250;
   localparam logic [TIME_W-1:0] HALF_TIME = 48'h8000_0000_0000;

   typedef struct packed {
      logic [RATE_W-1:0] long_bps;
      logic              long_ok;
      logic [RATE_W-1:0] slide_bps;
      logic              slide_ok;
   } rates_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsbrm_req_if req_bus ();
   tsbrm_rsp_if rsp_bus ();
   tsbrm_csr_if csr_bus ();

   ts_bitrate_meter u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // meter predictor state
   logic [LWIN_W-1:0]  m_lwin;
   logic [SLICE_W-1:0] m_slice;
   logic [PB_W-1:0]    m_pbits;
   logic               m_started;
   logic [TIME_W-1:0]  m_win_time;
   logic [COUNT_W-1:0] m_win_count;
   logic [RATE_W-1:0]  m_long;
   logic               m_long_ok;
   logic [TIME_W-1:0]  m_smp_time [RING_LEN];
   logic [COUNT_W-1:0] m_smp_count [RING_LEN];
   int unsigned        m_head;
   int unsigned        m_fill;
   logic [RATE_W-1:0]  m_slide;
   logic               m_slide_ok;

   rates_type          expected_rates [$];
   logic [TIME_W-1:0]  last_now;
   logic [COUNT_W-1:0] last_count;
   int unsigned        mismatches;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   int unsigned        hold_left;
   int unsigned        cycles;

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [RATE_W-1:0] bit_rate(logic [COUNT_W-1:0] pkts,
                                                  logic [TIME_W-1:0] span);
      logic [127:0] bits_us;
      logic [127:0] quot;
      if (span == '0) return (pkts != '0) ? RATE_MAX : '0;
      bits_us = 128'(pkts) * 128'(m_pbits) * 128'(US_PER_S);
      quot = bits_us / 128'(span);
      return (quot > 128'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
   endfunction

   function automatic rates_type predict_tick(logic [TIME_W-1:0] now,
                                              logic [COUNT_W-1:0] cnt);
      logic [TIME_W-1:0] span;
      logic              take;
      int unsigned       newest;
      int unsigned       slot;
      rates_type         r;
      if (!m_started) begin
         m_started = 1'b1;
         m_win_time = now;
         m_win_count = cnt;
      end else begin
         span = now - m_win_time;
         if (64'(span) >= 64'(m_lwin)) begin
            m_long = bit_rate(cnt - m_win_count, span);
            m_long_ok = 1'b1;
            m_win_time = now;
            m_win_count = cnt;
         end
      end
      take = (m_fill == 0);
      if (!take) begin
         newest = (m_head + m_fill - 1) % RING_LEN;
         take = (now - m_smp_time[newest]) >= TIME_W'(m_slice);
      end
      if (take) begin
         if (m_fill >= RING_LEN) begin
            m_head = (m_head + 1) % RING_LEN;
            slot = (m_head + SLICES) % RING_LEN;
         end else begin
            slot = (m_head + m_fill) % RING_LEN;
            m_fill++;
         end
         m_smp_time[slot] = now;
         m_smp_count[slot] = cnt;
         if (m_fill >= RING_LEN) begin
            m_slide = bit_rate(cnt - m_smp_count[m_head], now - m_smp_time[m_head]);
            m_slide_ok = 1'b1;
         end
      end
      r.long_bps = m_long;
      r.long_ok = m_long_ok;
      r.slide_bps = m_slide;
      r.slide_ok = m_slide_ok;
      return r;
   endfunction

   function automatic void check_field(string what, logic [RATE_W-1:0] want,
                                       logic [RATE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_results
      rates_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rates.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got long %0d/%0b sliding %0d/%0b",
                     $time, rsp_bus.long_rate_bps, rsp_bus.long_rate_valid,
                     rsp_bus.sliding_rate_bps, rsp_bus.sliding_rate_valid);
            mismatches++;
         end else begin
            want = expected_rates.pop_front();
            check_field("long_rate_bps", want.long_bps, rsp_bus.long_rate_bps);
            check_field("long_rate_valid", RATE_W'(want.long_ok),
                        RATE_W'(rsp_bus.long_rate_valid));
            check_field("sliding_rate_bps", want.slide_bps, rsp_bus.sliding_rate_bps);
            check_field("sliding_rate_valid", RATE_W'(want.slide_ok),
                        RATE_W'(rsp_bus.sliding_rate_valid));
         end
      end
   end

   // receiver: random stalls plus long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL ts_bitrate_meter");
      $finish;
   end

   task automatic send_tick(logic [TIME_W-1:0] now, logic [COUNT_W-1:0] cnt);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_us <= now;
      req_bus.packet_count <= cnt;
      do @(posedge clock); while (!req_bus.ready);
      expected_rates.push_back(predict_tick(now, cnt));
      last_now = now;
      last_count = cnt;
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rates.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_LONG_WINDOW: m_lwin = value;
         CSR_SLICE:       m_slice = value;
         CSR_PACKET_BITS: m_pbits = value[PB_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // mostly forward time steps around the slice, some repeats, jumps and wraps
   task automatic send_burst(int unsigned n);
      logic [TIME_W-1:0]  now;
      logic [COUNT_W-1:0] cnt;
      int unsigned        pick;
      longint unsigned    dt;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         dt = (64'(m_slice) * $urandom_range(0, 250)) / 100;
         if (pick < 4) now = rand48();
         else if (pick < 9) now = last_now;
         else if (pick < 12) now = last_now - $urandom_range(1, 1000);
         else now = last_now + TIME_W'(dt);
         pick = $urandom_range(0, 99);
         if (pick < 5) cnt = rand48();
         else if (pick < 12) cnt = last_count;
         else if (pick < 20) cnt = last_count + $urandom_range(0, 1 << 30);
         else cnt = last_count + $urandom_range(0, 40);
         send_tick(now, cnt);
      end
      req_idle();
   endtask

   task automatic pick_random_config();
      wait_drained();
      csr_write(CSR_LONG_WINDOW, $urandom_range(200, 3000));
      csr_write(CSR_SLICE, $urandom_range(20, 400));
      csr_write(CSR_PACKET_BITS, $urandom_range(1, 65535));
   endtask

   task automatic random_phase(int unsigned n, int unsigned sidle, int unsigned rstall);
      pick_random_config();
      send_idle_pct = sidle;
      stall_pct = rstall;
      send_burst(n);
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_default_window();
      send_tick(48'd1000, 48'd0);
      send_tick(48'd51000, 48'd10);
      send_tick(48'd101000, 48'd70);
      send_tick(48'd1001000, 48'd700);
      send_tick(48'd1001000, 48'd700);
      req_idle();
   endtask

   task automatic test_register_extremes();
      wait_drained();
      csr_write(CSR_LONG_WINDOW, 32'd1);
      csr_write(CSR_SLICE, 32'd1);
      csr_write(CSR_PACKET_BITS, 32'h0000_FFFF);
      csr_write(CSR_NONE, $urandom);
      send_tick(last_now + 48'd1, last_count + 48'h8000_0000_0000);
      send_tick(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE);
      send_tick(48'd3, 48'd5);     // time and count wrap
      send_tick(48'd2, 48'd6);     // time steps back
      req_idle();
      wait_drained();
      csr_write(CSR_LONG_WINDOW, 32'hFFFF_FFFF);
      csr_write(CSR_SLICE, 32'hFFFF_FFFF);
      csr_write(CSR_PACKET_BITS, 32'd1);
      send_tick(48'd2 + 48'hFFFF_FFFF, 48'd1006);
      send_tick(last_now + 48'hFFFF_FFFE, last_count + 48'd77);
      req_idle();
   endtask

   // alternating half-range times make the sliding span wrap to zero
   task automatic test_zero_span();
      logic [TIME_W-1:0]  base;
      logic [COUNT_W-1:0] second_count;
      wait_drained();
      csr_write(CSR_LONG_WINDOW, 32'd1);
      csr_write(CSR_SLICE, 32'd1);
      csr_write(CSR_PACKET_BITS, 32'(PB_RST));
      base = last_now + 48'd1;
      second_count = '0;
      for (int i = 0; i < 11; i++) begin
         send_tick((i % 2) ? base + HALF_TIME : base, last_count + 48'd3);
         if (i == 1) second_count = last_count;
      end
      send_tick(base + HALF_TIME, second_count);
      req_idle();
   endtask

   task automatic test_no_idling();
      random_phase(330, 0, 0);
   endtask

   task automatic test_sender_gaps();
      random_phase(330, 50, 0);
   endtask

   task automatic test_receiver_stalls();
      random_phase(330, 0, 50);
   endtask

   task automatic test_both_idle();
      random_phase(330, 19, 19);
   endtask

   task automatic test_extreme_windows();
      wait_drained();
      csr_write(CSR_LONG_WINDOW, 32'hFFFF_FFFF);
      csr_write(CSR_SLICE, 32'hFFFF_FFFF);
      csr_write(CSR_PACKET_BITS, 32'd1);
      send_burst(100);
      wait_drained();
      csr_write(CSR_LONG_WINDOW, 32'd1);
      csr_write(CSR_SLICE, 32'd1);
      csr_write(CSR_PACKET_BITS, 32'h0000_FFFF);
      send_burst(100);
   endtask

   task automatic test_backpressure();
      pick_random_config();
      hold_left = 400;
      send_burst(40);
      wait_drained();
      send_burst(20);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.now_us = '0;
      req_bus.packet_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_LONG_WINDOW;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      m_lwin = LWIN_RST;
      m_slice = SLICE_RST;
      m_pbits = PB_RST;
      m_started = 1'b0;
      m_win_time = '0;
      m_win_count = '0;
      m_long = '0;
      m_long_ok = 1'b0;
      m_head = 0;
      m_fill = 0;
      m_slide = '0;
      m_slide_ok = 1'b0;
      last_now = '0;
      last_count = '0;
      mismatches = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_window();
      test_register_extremes();
      test_zero_span();
      test_no_idling();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_extreme_windows();
      test_backpressure();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rates.size() == 0) begin
         $display("PASS ts_bitrate_meter");
      end else begin
         $display("FAIL ts_bitrate_meter");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/tsbrm_pkg.sv
rtl/tsbrm_ifs.sv
rtl/tsbrm_dp.sv
rtl/tsbrm_ctrl.sv
rtl/ts_bitrate_meter.sv
test/tb_ts_bitrate_meter.sv
